/* hdl/dlcrc_pkg.sv */
// Shared types, constants and the CRC-16 (poly 0x8005) word step for the
// dual-lane frame checker. No dependencies.
`timescale 1ns / 1ps

package dlcrc_pkg;

  localparam int DEF_MAX_BLOCKS  = 16;
  localparam int DEF_MAX_SAMPLES = 16;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] RST_BLOCKS_PER_FRAME = 5'd16;
  localparam logic [CFG_W-1:0] RST_SAMPLES_PER_GAIN = 5'd8;

  // configuration register indexes
  localparam logic CFG_BLOCKS_PER_FRAME = 1'b0;
  localparam logic CFG_SAMPLES_PER_GAIN = 1'b1;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_HDR1    = 4'd1,
    PH_DATA1   = 4'd2,
    PH_HDR2    = 4'd3,
    PH_DATA2   = 4'd4,
    PH_LANECRC = 4'd5,
    PH_CRCERR  = 4'd6,
    PH_GLOBAL  = 4'd7,
    PH_END     = 4'd8
  } phase_t;

  typedef enum logic [3:0] {
    KIND_START   = 4'd0,
    KIND_HDR1    = 4'd1,
    KIND_DATA1   = 4'd2,
    KIND_HDR2    = 4'd3,
    KIND_DATA2   = 4'd4,
    KIND_LANECRC = 4'd5,
    KIND_CRCERR  = 4'd6,
    KIND_GLOBAL  = 4'd7,
    KIND_END     = 4'd8,
    KIND_READERR = 4'd9
  } kind_t;

  // one classified word, front to back
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  blk;
    logic [3:0]  smp;
    logic        done;
    logic        crc_clear;
    logic        crc_update;
    logic [15:0] lane_even;
    logic [15:0] lane_odd;
  } item_t;

  localparam logic [15:0] CRC_MASKS [16] = '{
    16'hBFFF, 16'h7FFE, 16'h4003, 16'h8006,
    16'h000C, 16'h0018, 16'h0030, 16'h0060,
    16'h00C0, 16'h0180, 16'h0300, 16'h0600,
    16'h0C00, 16'h1800, 16'h3000, 16'hDFFF
  };

  // new bit i = parity((data ^ crc) & mask[i])
  function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                             input logic [15:0] data);
    logic [15:0] x;
    logic [15:0] n;
    x = crc ^ data;
    for (int i = 0; i < 16; i++) begin
      n[i] = ^(x & CRC_MASKS[i]);
    end
    return n;
  endfunction

endpackage

/* hdl/dual_lane_crc16_frame_checker_unit.sv */
// Top level of the dual-lane CRC-16 frame checker.
// Depends on dlcrc_pkg, dlcrc_front, dlcrc_queue, dlcrc_back.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready  | tdata link_word, tuser link_error
//  m_axis   | out       | m_axis_tvalid/tready  | tdata pos + CRCs, tuser kind, tlast
//  cfg      | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One word per clock sustained while m_axis_tready stays high. An accepted
// word goes through the queue: the front classifies it in its accept cycle,
// the back applies the XOR network to both lanes as it pops the queue into
// the output register. Synchronous reset empties the queue and output
// register and returns the phase to expecting a start word. Output stalls
// fill the queue, then drop s_axis_tready. cfg_ready is always high.
`timescale 1ns / 1ps

module dual_lane_crc16_frame_checker_unit import dlcrc_pkg::*; #(
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,  // [31:0] link_word
  input  logic             s_axis_tuser,  // [0] link_error
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [3:0] block_number, [7:4] sample_number,
                                          // [23:8] crc_lane_even, [39:24] crc_lane_odd
  output logic [3:0]       m_axis_tuser,  // [3:0] word_kind
  output logic             m_axis_tlast,  // frame_done
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  item_t front_item, q_item;
  logic  q_full, q_valid, q_pop, accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dlcrc_front #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .link_word  (s_axis_tdata),
    .link_error (s_axis_tuser),
    .item       (front_item)
  );

  dlcrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  dlcrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  // an accepted word is waiting in the queue at the next edge
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> q_valid)
    else $error("accepted word missing from queue");

  // frame_done only on end word or read error
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tuser == KIND_END || m_axis_tuser == KIND_READERR))
    else $error("frame_done on wrong word kind");

  // nonzero sample index only on sample words or read errors
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[7:4] != 4'd0) |->
      (m_axis_tuser == KIND_DATA1 || m_axis_tuser == KIND_DATA2 ||
       m_axis_tuser == KIND_READERR))
    else $error("sample index on non-sample word");

  // nothing leaves straight after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

/* hdl/dlcrc_front.sv */
// Front end: configuration registers, frame phase tracking and lane split.
// Depends on dlcrc_pkg.
`timescale 1ns / 1ps

module dlcrc_front import dlcrc_pkg::*; #(
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             accept,
  input  logic [31:0]      link_word,
  input  logic             link_error,
  output item_t            item
);

  localparam int BCW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int SCW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int BNW  = ($clog2(MAX_BLOCKS + 1) > CFG_W) ? $clog2(MAX_BLOCKS + 1) : CFG_W;
  localparam int SNW  = ($clog2(MAX_SAMPLES + 1) > CFG_W) ? $clog2(MAX_SAMPLES + 1) : CFG_W;

  logic [CFG_W-1:0] blocks_per_frame;
  logic [CFG_W-1:0] samples_per_gain;
  phase_t           phase, phase_next;
  logic [BCW-1:0]   block_count, block_count_next;
  logic [SCW-1:0]   sample_count, sample_count_next;

  logic [BNW-1:0]   nblk;
  logic [SNW-1:0]   nsmp;
  logic             last_block, last_sample;
  logic [BCW+3:0]   blk_ext;
  logic [SCW+3:0]   smp_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_per_frame <= RST_BLOCKS_PER_FRAME;
      samples_per_gain <= RST_SAMPLES_PER_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCKS_PER_FRAME: blocks_per_frame <= cfg_data;
        CFG_SAMPLES_PER_GAIN: samples_per_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero counts as one, anything above the maximum as the maximum
  always_comb begin
    if (blocks_per_frame == '0)
      nblk = BNW'(1);
    else if (BNW'(blocks_per_frame) > BNW'(MAX_BLOCKS))
      nblk = BNW'(MAX_BLOCKS);
    else
      nblk = BNW'(blocks_per_frame);
    if (samples_per_gain == '0)
      nsmp = SNW'(1);
    else if (SNW'(samples_per_gain) > SNW'(MAX_SAMPLES))
      nsmp = SNW'(MAX_SAMPLES);
    else
      nsmp = SNW'(samples_per_gain);
  end

  assign last_block  = (BNW'(block_count) + BNW'(1)) >= nblk;
  assign last_sample = (SNW'(sample_count) + SNW'(1)) >= nsmp;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      block_count  <= '0;
      sample_count <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      block_count  <= block_count_next;
      sample_count <= sample_count_next;
    end
  end

  // next state
  always_comb begin
    phase_next        = phase;
    block_count_next  = block_count;
    sample_count_next = sample_count;
    if (link_error) begin
      phase_next        = PH_START;
      block_count_next  = '0;
      sample_count_next = '0;
    end else begin
      case (phase)
        PH_HDR1: begin
          sample_count_next = '0;
          phase_next        = PH_DATA1;
        end
        PH_DATA1, PH_DATA2: begin
          if (last_sample) begin
            sample_count_next = '0;
            phase_next        = (phase == PH_DATA1) ? PH_HDR2 : PH_LANECRC;
          end else begin
            sample_count_next = sample_count + SCW'(1);
          end
        end
        PH_HDR2: begin
          sample_count_next = '0;
          phase_next        = PH_DATA2;
        end
        PH_LANECRC: begin
          if (last_block) begin
            phase_next = PH_CRCERR;
          end else begin
            block_count_next = block_count + BCW'(1);
            phase_next       = PH_HDR1;
          end
        end
        PH_CRCERR: phase_next = PH_GLOBAL;
        PH_GLOBAL: phase_next = PH_END;
        PH_END:    phase_next = PH_START;
        default: begin
          block_count_next  = '0;
          sample_count_next = '0;
          phase_next        = PH_HDR1;
        end
      endcase
    end
  end

  assign blk_ext = {4'b0000, block_count};
  assign smp_ext = {4'b0000, sample_count};

  // classification
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      item.lane_even[i] = link_word[30 - 2 * i];
      item.lane_odd[i]  = link_word[31 - 2 * i];
    end
    item.blk        = blk_ext[3:0];
    item.smp        = 4'd0;
    item.done       = 1'b0;
    item.crc_clear  = 1'b0;
    item.crc_update = 1'b0;
    item.kind       = KIND_START;
    if (link_error) begin
      item.kind = KIND_READERR;
      item.smp  = smp_ext[3:0];
      item.done = 1'b1;
    end else begin
      case (phase)
        PH_HDR1: begin
          item.kind       = KIND_HDR1;
          item.crc_clear  = 1'b1;
          item.crc_update = 1'b1;
        end
        PH_DATA1: begin
          item.kind       = KIND_DATA1;
          item.smp        = smp_ext[3:0];
          item.crc_update = 1'b1;
        end
        PH_HDR2: begin
          item.kind       = KIND_HDR2;
          item.crc_update = 1'b1;
        end
        PH_DATA2: begin
          item.kind       = KIND_DATA2;
          item.smp        = smp_ext[3:0];
          item.crc_update = 1'b1;
        end
        PH_LANECRC: item.kind = KIND_LANECRC;
        PH_CRCERR:  item.kind = KIND_CRCERR;
        PH_GLOBAL:  item.kind = KIND_GLOBAL;
        PH_END: begin
          item.kind = KIND_END;
          item.done = 1'b1;
        end
        default: begin
          item.kind = KIND_START;
          item.blk  = 4'd0;
        end
      endcase
    end
  end

endmodule

/* hdl/dlcrc_queue.sv */
// Short FIFO of classified words between front and back end.
// Depends on dlcrc_pkg.
`timescale 1ns / 1ps

module dlcrc_queue import dlcrc_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

/* hdl/dlcrc_back.sv */
// Back end: both lane CRC registers and the output register.
// Depends on dlcrc_pkg.
`timescale 1ns / 1ps

module dlcrc_back import dlcrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic [39:0] out_data,
  output logic        out_last
);

  logic [15:0] crc_even, crc_odd;
  logic [15:0] crc_even_next, crc_odd_next;
  logic [15:0] base_even, base_odd;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    base_even     = q_item.crc_clear ? 16'h0000 : crc_even;
    base_odd      = q_item.crc_clear ? 16'h0000 : crc_odd;
    crc_even_next = crc_even;
    crc_odd_next  = crc_odd;
    if (q_item.crc_update) begin
      crc_even_next = crc16_step(base_even, q_item.lane_even);
      crc_odd_next  = crc16_step(base_odd, q_item.lane_odd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_even  <= '0;
      crc_odd   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        crc_even  <= crc_even_next;
        crc_odd   <= crc_odd_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind <= q_item.kind;
      out_data <= {crc_odd_next, crc_even_next, q_item.smp, q_item.blk};
      out_last <= q_item.done;
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for dual_lane_crc16_frame_checker_unit: link words in on s_axis,
// classified words out on m_axis, checked against an in-bench frame tracker.
// Depends on dlcrc_pkg and the unit RTL.

module tb_top;
  import dlcrc_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RST_CYCLES  = 7;
  localparam int WORD_TARGET = 1550;
  localparam int CALM_WORDS  = 150;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  // parity taps of the 16-bit parallel 0x8005 network, one per result bit
  localparam logic [15:0] POLY_TAPS [16] = '{
    16'hBFFF, 16'h7FFE, 16'h4003, 16'h8006,
    16'h000C, 16'h0018, 16'h0030, 16'h0060,
    16'h00C0, 16'h0180, 16'h0300, 16'h0600,
    16'h0C00, 16'h1800, 16'h3000, 16'hDFFF
  };

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  blk;
    logic [3:0]  smp;
    logic [15:0] crc_even;
    logic [15:0] crc_odd;
    logic        done;
  } word_report_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [39:0]      m_axis_tdata;
  logic [3:0]       m_axis_tuser;
  logic             m_axis_tlast;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = CFG_BLOCKS_PER_FRAME;
  logic [CFG_W-1:0] cfg_data = '0;

  // frame tracker state and its copy of the registers
  phase_t           trk_phase = PH_START;
  logic [3:0]       trk_block = '0;
  logic [3:0]       trk_sample = '0;
  logic [15:0]      trk_crc_even = '0;
  logic [15:0]      trk_crc_odd = '0;
  logic [CFG_W-1:0] trk_blocks_cfg = RST_BLOCKS_PER_FRAME;
  logic [CFG_W-1:0] trk_samples_cfg = RST_SAMPLES_PER_GAIN;

  word_report_t expected_reports[$];
  word_report_t head_report;
  int           mismatches = 0;
  int           words_sent = 0;
  int           cycle_count = 0;
  bit           src_gaps = 1'b1;
  bit           sink_gaps = 1'b1;
  int           hold_requests = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           stall_left = 0;

  dual_lane_crc16_frame_checker_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // lane bit 0 is word bit 'top' (30 even, 31 odd), then every second bit down
  function automatic logic [15:0] lane_slice(input logic [31:0] w, input int top);
    logic [15:0] v;
    for (int i = 0; i < 16; i++) v[i] = w[top - 2 * i];
    return v;
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [15:0] d);
    logic [15:0] x;
    logic [15:0] n;
    x = c ^ d;
    for (int i = 0; i < 16; i++) n[i] = ^(x & POLY_TAPS[i]);
    return n;
  endfunction

  function automatic int effective_count(input logic [CFG_W-1:0] v, input int ceiling);
    if (v == 0) return 1;
    if (int'(v) > ceiling) return ceiling;
    return int'(v);
  endfunction

  function automatic word_report_t classify_link_word(input logic [31:0] w, input logic err);
    word_report_t r;
    int           nblk;
    int           nsmp;
    bit           fold;
    nblk   = effective_count(trk_blocks_cfg, DEF_MAX_BLOCKS);
    nsmp   = effective_count(trk_samples_cfg, DEF_MAX_SAMPLES);
    fold   = 1'b0;
    r.kind = KIND_START;
    r.blk  = trk_block;
    r.smp  = '0;
    r.done = 1'b0;
    if (err) begin
      // abandon the frame; CRCs hold, position is the one that was expected
      r.kind     = KIND_READERR;
      r.smp      = trk_sample;
      r.done     = 1'b1;
      trk_phase  = PH_START;
      trk_block  = '0;
      trk_sample = '0;
    end else begin
      case (trk_phase)
        PH_HDR1: begin
          r.kind       = KIND_HDR1;
          trk_crc_even = '0;
          trk_crc_odd  = '0;
          fold         = 1'b1;
          trk_sample   = '0;
          trk_phase    = PH_DATA1;
        end
        PH_HDR2: begin
          r.kind     = KIND_HDR2;
          fold       = 1'b1;
          trk_sample = '0;
          trk_phase  = PH_DATA2;
        end
        PH_DATA1, PH_DATA2: begin
          r.kind = (trk_phase == PH_DATA1) ? KIND_DATA1 : KIND_DATA2;
          r.smp  = trk_sample;
          fold   = 1'b1;
          if (int'(trk_sample) + 1 >= nsmp) begin
            trk_sample = '0;
            trk_phase  = (trk_phase == PH_DATA1) ? PH_HDR2 : PH_LANECRC;
          end else begin
            trk_sample = trk_sample + 4'd1;
          end
        end
        PH_LANECRC: begin
          r.kind = KIND_LANECRC;
          if (int'(trk_block) + 1 >= nblk) begin
            trk_phase = PH_CRCERR;
          end else begin
            trk_block = trk_block + 4'd1;
            trk_phase = PH_HDR1;
          end
        end
        PH_CRCERR: begin
          r.kind    = KIND_CRCERR;
          trk_phase = PH_GLOBAL;
        end
        PH_GLOBAL: begin
          r.kind    = KIND_GLOBAL;
          trk_phase = PH_END;
        end
        PH_END: begin
          r.kind    = KIND_END;
          r.done    = 1'b1;
          trk_phase = PH_START;
        end
        default: begin
          r.kind     = KIND_START;
          r.blk      = '0;
          trk_block  = '0;
          trk_sample = '0;
          trk_phase  = PH_HDR1;
        end
      endcase
    end
    if (fold) begin
      trk_crc_even = crc_step(trk_crc_even, lane_slice(w, 30));
      trk_crc_odd  = crc_step(trk_crc_odd, lane_slice(w, 31));
    end
    r.crc_even = trk_crc_even;
    r.crc_odd  = trk_crc_odd;
    return r;
  endfunction

  function automatic logic [31:0] random_link_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_count(input int typical_max);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_W'($urandom_range(DEF_MAX_BLOCKS, 31));
      default: return CFG_W'($urandom_range(1, typical_max));
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // valid drops only in random gaps (src_gaps); otherwise back-to-back calls stream
  task automatic send_word(input logic [31:0] w, input logic err);
    if (src_gaps && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= err;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_reports.push_back(classify_link_word(w, err));
    words_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // both registers in two back-to-back transactions, only with the unit idle
  task automatic write_cfg(input logic [CFG_W-1:0] blocks, input logic [CFG_W-1:0] samples);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BLOCKS_PER_FRAME;
    cfg_data  <= blocks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    trk_blocks_cfg = blocks;
    cfg_index <= CFG_SAMPLES_PER_GAIN;
    cfg_data  <= samples;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    trk_samples_cfg = samples;
    cfg_valid <= 1'b0;
  endtask

  // a whole frame at the current counts; an injected read error ends it early
  task automatic send_frame(input int err_permille);
    int  total;
    bit  err;
    total = 4 + effective_count(trk_blocks_cfg, DEF_MAX_BLOCKS) *
                (3 + 2 * effective_count(trk_samples_cfg, DEF_MAX_SAMPLES));
    for (int i = 0; i < total; i++) begin
      err = ($urandom_range(0, 999) < err_permille);
      send_word(random_link_word(), err);
      if (err) return;
    end
  endtask

  task automatic test_directed();
    // reset counts: error while idle, then an error part way into gain-1 samples
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    write_cfg(5'd1, 5'd1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    send_word(32'h7FFF_FFFE, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'hDEAD_BEEF, 1'b0);
    send_word(32'h0F0F_F0F0, 1'b0);
    send_word(32'hFFFF_0000, 1'b0);
    // zero in either register behaves as one
    write_cfg(5'd0, 5'd0);
    send_frame(0);
  endtask

  task automatic test_count_extremes();
    write_cfg(5'd31, 5'd1);
    send_frame(0);
    write_cfg(5'd1, 5'd16);
    send_frame(0);
    write_cfg(5'd2, 5'd31);
    send_frame(0);
  endtask

  task automatic test_output_backpressure();
    write_cfg(5'd3, 5'd4);
    src_gaps = 1'b0;
    hold_requests++;
    send_frame(0);
    src_gaps = 1'b1;
  endtask

  task automatic test_drain_pause();
    write_cfg(5'd2, 5'd3);
    repeat (10) send_word(random_link_word(), 1'b0);
    wait_drained();
    repeat (12) send_word(random_link_word(), 1'b0);
  endtask

  task automatic test_random_frames(input int upto, input bit with_gaps);
    int frames;
    int total;
    frames = 0;
    while (words_sent < upto) begin
      if (frames % 3 == 0) write_cfg(pick_count(4), pick_count(6));
      src_gaps  = with_gaps && ($urandom_range(0, 3) != 0);
      sink_gaps = with_gaps && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          // stray failed reads between frames
          repeat ($urandom_range(1, 3)) send_word(random_link_word(), 1'b1);
        end
        1: begin
          // truncated frame, recovered by a failed read
          total = 4 + effective_count(trk_blocks_cfg, DEF_MAX_BLOCKS) *
                      (3 + 2 * effective_count(trk_samples_cfg, DEF_MAX_SAMPLES));
          repeat ($urandom_range(1, total - 1)) send_word(random_link_word(), 1'b0);
          send_word(random_link_word(), 1'b1);
        end
        default: send_frame(5);
      endcase
      frames++;
    end
  endtask

  // result sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen     <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 11) == 0) begin
      stall_left    <= $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual kind %0h tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        head_report = expected_reports.pop_front();
        check_field("word_kind", head_report.kind, m_axis_tuser);
        check_field("block_number", head_report.blk, m_axis_tdata[3:0]);
        check_field("sample_number", head_report.smp, m_axis_tdata[7:4]);
        check_field("crc_lane_even", head_report.crc_even, m_axis_tdata[23:8]);
        check_field("crc_lane_odd", head_report.crc_odd, m_axis_tdata[39:24]);
        check_field("frame_done", head_report.done, m_axis_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dual_lane_crc16_frame_checker_unit test failed");
      $finish;
    end
  end

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_count_extremes();
    test_output_backpressure();
    test_drain_pause();
    test_random_frames(WORD_TARGET - CALM_WORDS, 1'b1);
    test_random_frames(WORD_TARGET, 1'b0);
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("dual_lane_crc16_frame_checker_unit test passed");
    end else begin
      $display("dual_lane_crc16_frame_checker_unit test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/dlcrc_pkg.sv
hdl/dlcrc_front.sv
hdl/dlcrc_queue.sv
hdl/dlcrc_back.sv
hdl/dual_lane_crc16_frame_checker_unit.sv
tb/tb_top.sv
